// ===== src/ashc_pkg.sv =====
`default_nettype none

package ashc_pkg;

  // fixed field and counter widths
  localparam int OFFSET_BITS    = 32;
  localparam int BACKOFF_BITS   = 8;
  localparam int PACE_BITS      = 3;
  localparam int ALIGN_BITS     = 6;
  localparam int SETTLE_BITS    = 4;
  localparam int REG_INDEX_BITS = 3;
  localparam int PHASE_BITS     = 3;
  localparam int RESULT_BITS    = 3;

  // homing constants
  localparam int COARSE_MARGIN = 100;
  localparam logic [BACKOFF_BITS-1:0] BACKOFF_LOAD = 8'd50;
  localparam logic [BACKOFF_BITS-1:0] FINE_BUDGET  = 8'd100;
  localparam logic [PACE_BITS-1:0]    PACE_LOAD    = 3'd4;
  localparam logic [ALIGN_BITS-1:0]   ALIGN_LOAD   = 6'd50;
  localparam logic [SETTLE_BITS-1:0]  SETTLE_LOAD  = 4'd12;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_HOME   = 2'd2,
    OP_RELOAD = 2'd3
  } opcode_t;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE    = 3'd0,
    PH_COARSE  = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_FINE    = 3'd3,
    PH_DECIDE  = 3'd4,
    PH_ALIGN   = 3'd5
  } phase_t;

  typedef enum logic [RESULT_BITS-1:0] {
    RES_NONE        = 3'd0,
    RES_OK          = 3'd1,
    RES_COARSE_FAIL = 3'd2,
    RES_STUCK       = 3'd3,
    RES_FINE_FAIL   = 3'd4,
    RES_ALIGN_FAIL  = 3'd5,
    RES_KILLED      = 3'd6
  } result_t;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_LOWER   = 3'd0,
    REG_UPPER   = 3'd1,
    REG_CENTRE  = 3'd2,
    REG_HOME    = 3'd3,
    REG_SPAN    = 3'd4,
    REG_DUAL    = 3'd5,
    REG_REV_PRI = 3'd6,
    REG_REV_SEC = 3'd7
  } cfg_reg_t;

  // single-bit axis options
  typedef struct packed {
    logic dual_axis;
    logic reverse_primary;
    logic reverse_secondary;
  } ashc_flags_t;

endpackage

`default_nettype wire

// ===== src/ashc_in_if.sv =====
`default_nettype none

interface ashc_in_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic                     run_enable;
  logic                     home_switch_primary;
  logic                     home_switch_secondary;
  logic [POSITION_BITS-1:0] demand_delta;

  modport source (
    output valid, opcode, run_enable, home_switch_primary, home_switch_secondary,
           demand_delta,
    input  ready
  );

  modport sink (
    input  valid, opcode, run_enable, home_switch_primary, home_switch_secondary,
           demand_delta,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/ashc_out_if.sv =====
`default_nettype none

interface ashc_out_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     step_primary;
  logic                     step_secondary;
  logic                     dir_primary;
  logic                     dir_secondary;
  logic                     moving;
  logic                     settled;
  logic [POSITION_BITS-1:0] axis_position;
  logic [POSITION_BITS-1:0] target_position;
  logic [2:0]               homing_phase;
  logic [2:0]               home_result;
  logic [POSITION_BITS-1:0] home_offset;

  modport source (
    output valid, step_primary, step_secondary, dir_primary, dir_secondary, moving,
           settled, axis_position, target_position, homing_phase, home_result,
           home_offset,
    input  ready
  );

  modport sink (
    input  valid, step_primary, step_secondary, dir_primary, dir_secondary, moving,
           settled, axis_position, target_position, homing_phase, home_result,
           home_offset,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/ashc_cfg_if.sv =====
`default_nettype none

interface ashc_cfg_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               reg_index;
  logic [POSITION_BITS-1:0] wr_data;

  modport source (
    output valid, reg_index, wr_data,
    input  ready
  );

  modport sink (
    input  valid, reg_index, wr_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/ashc_cfg_regs.sv =====
`default_nettype none

module ashc_cfg_regs #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     wr_en,
  input  logic [ashc_pkg::REG_INDEX_BITS-1:0]      reg_index,
  input  logic [POSITION_BITS-1:0]                 wr_data,
  output logic signed [POSITION_BITS-1:0]          lower_limit,
  output logic signed [POSITION_BITS-1:0]          upper_limit,
  output logic signed [POSITION_BITS-1:0]          centre_position,
  output logic signed [POSITION_BITS-1:0]          home_position,
  output logic signed [POSITION_BITS-1:0]          travel_span,
  output ashc_pkg::ashc_flags_t                    flags
);
  import ashc_pkg::*;

  logic signed [POSITION_BITS-1:0] lower_r, upper_r, centre_r, home_r, span_r;
  ashc_flags_t                     flags_r;

  // register file write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r  <= '0;
      upper_r  <= '0;
      centre_r <= '0;
      home_r   <= '0;
      span_r   <= '0;
      flags_r  <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(reg_index))
        REG_LOWER:   lower_r  <= wr_data;
        REG_UPPER:   upper_r  <= wr_data;
        REG_CENTRE:  centre_r <= wr_data;
        REG_HOME:    home_r   <= wr_data;
        REG_SPAN:    span_r   <= wr_data;
        REG_DUAL:    flags_r.dual_axis         <= wr_data[0];
        REG_REV_PRI: flags_r.reverse_primary   <= wr_data[0];
        REG_REV_SEC: flags_r.reverse_secondary <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign lower_limit     = lower_r;
  assign upper_limit     = upper_r;
  assign centre_position = centre_r;
  assign home_position   = home_r;
  assign travel_span     = span_r;
  assign flags           = flags_r;

endmodule

`default_nettype wire

// ===== src/axis_stepper_homing_controller.sv =====
// Step/direction axis controller with homing, one or two motors.
// in_chan carries one request per operation: tick, target change, homing
// start or target reload. out_chan returns exactly one result per request,
// with the step pulses of that request and the state after it.
// cfg_chan writes the eight setup registers by index; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce that.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes each result; the
// whole update is one pass of logic between the state registers and the result
// register. in_chan.ready is high while the result register is empty or being taken,
// so a stalled receiver holds one result and then stops the input side
// without losing or repeating anything.
// Reset (rst_n low, synchronous) clears position, target, homing state,
// counters, direction levels, setup registers and the result valid flag.
`default_nettype none

module axis_stepper_homing_controller #(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ashc_in_if.sink    in_chan,
  ashc_out_if.source out_chan,
  ashc_cfg_if.sink   cfg_chan
);
  import ashc_pkg::*;

  localparam int SUM_BITS   = POSITION_BITS + 1;
  localparam int CHECK_BITS = OFFSET_BITS + 2;
  localparam logic signed [CHECK_BITS-1:0] MARGIN = CHECK_BITS'(COARSE_MARGIN);

  // setup registers
  logic signed [POSITION_BITS-1:0] lower_limit, upper_limit, centre_position;
  logic signed [POSITION_BITS-1:0] home_position, travel_span;
  ashc_flags_t                     flags;

  ashc_cfg_regs #(
    .POSITION_BITS(POSITION_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (cfg_chan.valid),
    .reg_index      (cfg_chan.reg_index),
    .wr_data        (cfg_chan.wr_data),
    .lower_limit    (lower_limit),
    .upper_limit    (upper_limit),
    .centre_position(centre_position),
    .home_position  (home_position),
    .travel_span    (travel_span),
    .flags          (flags)
  );

  assign cfg_chan.ready = 1'b1;

  // axis state
  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt, tgt_r, tgt_nxt;
  logic signed [OFFSET_BITS-1:0]   offset_r, offset_nxt;
  phase_t                          phase_r, phase_nxt;
  result_t                         result_r, result_nxt;
  logic [BACKOFF_BITS-1:0]         backoff_r, backoff_nxt;
  logic [PACE_BITS-1:0]            pace_r, pace_nxt;
  logic [ALIGN_BITS-1:0]           align_r, align_nxt;
  logic [SETTLE_BITS-1:0]          settle_r, settle_nxt;
  logic                            moving_r, moving_nxt;
  logic                            dirp_r, dirp_nxt, dirs_r, dirs_nxt;
  logic                            step1_nxt, step2_nxt;

  // result register
  logic                            out_valid_r;
  logic                            step1_r, step2_r;

  logic accept;

  assign in_chan.ready = rst_n & (~out_valid_r | out_chan.ready);
  assign accept        = in_chan.valid & in_chan.ready;

  // next state and result of one request
  always_comb begin
    logic                            sw1, sw2, sw, pulse, done;
    logic signed [SUM_BITS-1:0]      sum, clamped;
    logic signed [OFFSET_BITS-1:0]   off_dec;
    logic signed [CHECK_BITS-1:0]    coarse_chk;
    logic [PACE_BITS-1:0]            pace_dec;

    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    offset_nxt  = offset_r;
    phase_nxt   = phase_r;
    result_nxt  = result_r;
    backoff_nxt = backoff_r;
    pace_nxt    = pace_r;
    align_nxt   = align_r;
    settle_nxt  = settle_r;
    moving_nxt  = moving_r;
    dirp_nxt    = dirp_r;
    dirs_nxt    = dirs_r;
    step1_nxt   = 1'b0;
    step2_nxt   = 1'b0;
    pulse       = 1'b0;
    done        = 1'b0;

    sw1 = in_chan.home_switch_primary;
    sw2 = flags.dual_axis ? in_chan.home_switch_secondary : in_chan.home_switch_primary;
    sw  = sw1 | sw2;

    // clamped target change, upper limit wins when limits cross
    sum = SUM_BITS'(tgt_r) + SUM_BITS'(signed'(in_chan.demand_delta));
    clamped = sum;
    if (clamped < SUM_BITS'(lower_limit)) clamped = SUM_BITS'(lower_limit);
    if (clamped > SUM_BITS'(upper_limit)) clamped = SUM_BITS'(upper_limit);

    off_dec    = offset_r - OFFSET_BITS'(1);
    coarse_chk = CHECK_BITS'(off_dec) + CHECK_BITS'(travel_span) + MARGIN;
    pace_dec   = pace_r - PACE_BITS'(1);

    unique case (opcode_t'(in_chan.opcode))
      OP_ADD: tgt_nxt = clamped[POSITION_BITS-1:0];
      OP_HOME: begin
        phase_nxt   = PH_COARSE;
        result_nxt  = RES_NONE;
        offset_nxt  = '0;
        backoff_nxt = '0;
      end
      OP_RELOAD: tgt_nxt = centre_position;
      OP_TICK: begin
        if (settle_r != '0) settle_nxt = settle_r - SETTLE_BITS'(1);
        if (!in_chan.run_enable) begin
          // disabled tick kills homing
          if (phase_r != PH_IDLE) begin
            phase_nxt  = PH_IDLE;
            result_nxt = RES_KILLED;
          end
        end else begin
          moving_nxt = 1'b0;
          unique case (phase_r)
            PH_IDLE: begin
              if (tgt_r > pos_r) begin
                if (pos_r < upper_limit) begin
                  dirp_nxt = ~flags.reverse_primary;
                  if (flags.dual_axis) dirs_nxt = ~flags.reverse_secondary;
                  pos_nxt = pos_r + POSITION_BITS'(1);
                  pulse   = 1'b1;
                end
              end else if (tgt_r < pos_r) begin
                if (pos_r > lower_limit) begin
                  dirp_nxt = flags.reverse_primary;
                  if (flags.dual_axis) dirs_nxt = flags.reverse_secondary;
                  pos_nxt = pos_r - POSITION_BITS'(1);
                  pulse   = 1'b1;
                end
              end
            end
            PH_COARSE: begin
              if (!sw) begin
                dirp_nxt = flags.reverse_primary;
                if (flags.dual_axis) dirs_nxt = flags.reverse_secondary;
                offset_nxt = off_dec;
                if (coarse_chk[CHECK_BITS-1]) begin
                  result_nxt = RES_COARSE_FAIL;
                  phase_nxt  = PH_IDLE;
                end else begin
                  pulse = 1'b1;
                end
              end else begin
                phase_nxt   = PH_BACKOFF;
                backoff_nxt = BACKOFF_LOAD;
              end
            end
            PH_BACKOFF: begin
              dirp_nxt = ~flags.reverse_primary;
              if (flags.dual_axis) dirs_nxt = ~flags.reverse_secondary;
              pulse      = 1'b1;
              offset_nxt = offset_r + OFFSET_BITS'(1);
              if (backoff_r == '0) begin
                backoff_nxt = FINE_BUDGET;
                if (sw) begin
                  result_nxt = RES_STUCK;
                  phase_nxt  = PH_IDLE;
                end else begin
                  phase_nxt = PH_FINE;
                  pace_nxt  = PACE_LOAD;
                end
              end else begin
                backoff_nxt = backoff_r - BACKOFF_BITS'(1);
              end
            end
            PH_FINE: begin
              if (!sw) begin
                dirp_nxt = flags.reverse_primary;
                if (flags.dual_axis) dirs_nxt = flags.reverse_secondary;
                if (backoff_r == '0) begin
                  result_nxt = RES_FINE_FAIL;
                  phase_nxt  = PH_IDLE;
                end else begin
                  pace_nxt = pace_dec;
                  if (pace_dec == '0) begin
                    pulse       = 1'b1;
                    pace_nxt    = PACE_LOAD;
                    offset_nxt  = off_dec;
                    backoff_nxt = backoff_r - BACKOFF_BITS'(1);
                  end
                end
              end else begin
                phase_nxt = PH_DECIDE;
              end
            end
            PH_DECIDE: begin
              if (flags.dual_axis) begin
                phase_nxt = PH_ALIGN;
                align_nxt = ALIGN_LOAD;
                pace_nxt  = PACE_LOAD;
              end else begin
                done = 1'b1;
              end
            end
            PH_ALIGN: begin
              if (sw1 && sw2) begin
                done = 1'b1;
              end else if (align_r == '0) begin
                phase_nxt  = PH_IDLE;
                result_nxt = RES_ALIGN_FAIL;
              end else begin
                pace_nxt = pace_dec;
                if (pace_dec == '0) begin
                  pace_nxt  = PACE_LOAD;
                  align_nxt = align_r - ALIGN_BITS'(1);
                  if (!sw1) begin
                    dirp_nxt  = flags.reverse_primary;
                    step1_nxt = 1'b1;
                  end
                  if (flags.dual_axis && !sw2) begin
                    dirs_nxt  = flags.reverse_secondary;
                    step2_nxt = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
          // successful homing
          if (done) begin
            phase_nxt  = PH_IDLE;
            offset_nxt = offset_r + OFFSET_BITS'(pos_r);
            pos_nxt    = home_position;
            tgt_nxt    = home_position;
            result_nxt = RES_OK;
          end
          // common step pulse
          if (pulse) begin
            step1_nxt  = 1'b1;
            step2_nxt  = flags.dual_axis;
            moving_nxt = 1'b1;
            settle_nxt = SETTLE_LOAD;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      tgt_r     <= '0;
      offset_r  <= '0;
      phase_r   <= PH_IDLE;
      result_r  <= RES_NONE;
      backoff_r <= '0;
      pace_r    <= '0;
      align_r   <= '0;
      settle_r  <= '0;
      moving_r  <= 1'b0;
      dirp_r    <= 1'b0;
      dirs_r    <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      result_r  <= result_nxt;
      backoff_r <= backoff_nxt;
      pace_r    <= pace_nxt;
      align_r   <= align_nxt;
      settle_r  <= settle_nxt;
      moving_r  <= moving_nxt;
      dirp_r    <= dirp_nxt;
      dirs_r    <= dirs_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // step pulses are the only result fields not held in the state
  always_ff @(posedge clk) begin
    if (accept) begin
      step1_r <= step1_nxt;
      step2_r <= step2_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.step_primary    = step1_r;
  assign out_chan.step_secondary  = step2_r;
  assign out_chan.dir_primary     = dirp_r;
  assign out_chan.dir_secondary   = dirs_r;
  assign out_chan.moving          = moving_r;
  assign out_chan.settled         = (settle_r == '0);
  assign out_chan.axis_position   = pos_r;
  assign out_chan.target_position = tgt_r;
  assign out_chan.homing_phase    = phase_r;
  assign out_chan.home_result     = result_r;
  assign out_chan.home_offset     = offset_r[POSITION_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/ashc_checker.sv =====
`default_nettype none

module ashc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_step_primary,
  input logic       out_step_secondary,
  input logic [2:0] out_homing_phase,
  input logic [2:0] out_home_result
);
  import ashc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every accepted request gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted request");

  // only ticks can step a motor
  a_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_TICK)
    |=> !out_step_primary && !out_step_secondary)
    else $error("step pulse from a non-tick request");

  // homing in progress carries no outcome yet
  a_phase_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_homing_phase != PH_IDLE) |-> (out_home_result == RES_NONE))
    else $error("homing outcome set while homing");

endmodule

bind axis_stepper_homing_controller ashc_checker u_ashc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_opcode         (in_chan.opcode),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_step_primary  (out_chan.step_primary),
  .out_step_secondary(out_chan.step_secondary),
  .out_homing_phase  (out_chan.homing_phase),
  .out_home_result   (out_chan.home_result)
);

`default_nettype wire
